### hw/rtl/tpwm_pkg.sv
// ----------------------------------------------------------------------------
// tpwm_pkg
// Shared widths, register map and reset values of the tone PWM calculator.
// ----------------------------------------------------------------------------
package tpwm_pkg;

    localparam int ClkW    = 30;           // timer clock register width
    localparam int PerW    = 16;           // period, prescaler, compare, duty
    localparam int VolW    = 10;           // volume fields
    localparam int ToneW   = 16;           // tone frequency
    localparam int DivDenW = 33;           // divisor width of the timer dividers
    localparam int DataW   = 32;           // APB data width
    localparam int AddrW   = 5;            // APB address width
    localparam int IdxW    = 3;            // register index width

    localparam logic [IdxW-1:0] RegClk  = 3'd0;
    localparam logic [IdxW-1:0] RegMaxP = 3'd1;
    localparam logic [IdxW-1:0] RegDMin = 3'd2;
    localparam logic [IdxW-1:0] RegDMax = 3'd3;
    localparam logic [IdxW-1:0] RegVMin = 3'd4;
    localparam logic [IdxW-1:0] RegVMax = 3'd5;

    localparam logic [ClkW-1:0] RstClk  = 30'd240000000;
    localparam logic [PerW-1:0] RstMaxP = 16'd65535;
    localparam logic [PerW-1:0] RstDMin = 16'd0;
    localparam logic [PerW-1:0] RstDMax = 16'd52429;
    localparam logic [VolW-1:0] RstVMin = 10'd0;
    localparam logic [VolW-1:0] RstVMax = 10'd100;

    typedef logic [IdxW-1:0] t_reg_idx;

endpackage

### hw/rtl/tpwm_in_if.sv
// ----------------------------------------------------------------------------
// tpwm_in_if
// Request channel: tone frequency and loudness with valid/ready.
// ----------------------------------------------------------------------------
interface tpwm_in_if;
    logic                        valid;
    logic                        ready;
    logic [tpwm_pkg::ToneW-1:0]  tone_hz;
    logic [tpwm_pkg::VolW-1:0]   loudness;

    modport source (output valid, output tone_hz, output loudness, input ready);
    modport sink   (input valid, input tone_hz, input loudness, output ready);
endinterface

### hw/rtl/tpwm_out_if.sv
// ----------------------------------------------------------------------------
// tpwm_out_if
// Result channel: timer settings with valid/ready.
// ----------------------------------------------------------------------------
interface tpwm_out_if;
    logic                       valid;
    logic                       ready;
    logic                       silent;
    logic [tpwm_pkg::PerW-1:0]  prescaler;
    logic [tpwm_pkg::PerW-1:0]  period;
    logic [tpwm_pkg::PerW-1:0]  compare;

    modport source (output valid, output silent, output prescaler, output period,
                    output compare, input ready);
    modport sink   (input valid, input silent, input prescaler, input period,
                    input compare, output ready);
endinterface

### hw/rtl/tpwm_div_cell.sv
// ----------------------------------------------------------------------------
// tpwm_div_cell
// One restoring-division cell: resolves one quotient bit per item.
// ----------------------------------------------------------------------------
module tpwm_div_cell #(
    parameter int NW  = 30,
    parameter int DW  = 33,
    parameter int SBW = 1,
    parameter int BIT = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [NW-1:0]  i_num,
    input  logic [DW-1:0]  i_den,
    input  logic [DW-1:0]  i_rem,
    input  logic [NW-1:0]  i_quot,
    input  logic [SBW-1:0] i_sb,
    output logic           o_valid,
    output logic [NW-1:0]  o_num,
    output logic [DW-1:0]  o_den,
    output logic [DW-1:0]  o_rem,
    output logic [NW-1:0]  o_quot,
    output logic [SBW-1:0] o_sb
);
    logic [DW:0]    w_trial;
    logic [DW:0]    w_diff;
    logic           w_ge;
    logic [NW-1:0]  n_quot;
    logic [DW-1:0]  n_rem;
    logic           r_valid;
    logic [NW-1:0]  r_num;
    logic [DW-1:0]  r_den;
    logic [DW-1:0]  r_rem;
    logic [NW-1:0]  r_quot;
    logic [SBW-1:0] r_sb;

    assign w_trial = {i_rem, i_num[BIT]};
    assign w_diff  = w_trial - {1'b0, i_den};
    assign w_ge    = (w_trial >= {1'b0, i_den});

    always_comb begin
        n_quot      = i_quot;
        n_quot[BIT] = w_ge;
        n_rem       = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= n_rem;
            r_quot <= n_quot;
            r_sb   <= i_sb;
        end
    end

    assign o_valid = r_valid;
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_rem   = r_rem;
    assign o_quot  = r_quot;
    assign o_sb    = r_sb;
endmodule

### hw/rtl/tpwm_div_chain.sv
// ----------------------------------------------------------------------------
// tpwm_div_chain
// Row of division cells, most significant quotient bit first.
// ----------------------------------------------------------------------------
module tpwm_div_chain #(
    parameter int NW  = 30,
    parameter int DW  = 33,
    parameter int SBW = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [NW-1:0]  i_num,
    input  logic [DW-1:0]  i_den,
    input  logic [SBW-1:0] i_sb,
    output logic           o_valid,
    output logic [NW-1:0]  o_quot,
    output logic [SBW-1:0] o_sb
);
    logic [NW:0]            w_valid;
    logic [NW:0][NW-1:0]    w_num;
    logic [NW:0][DW-1:0]    w_den;
    logic [NW:0][DW-1:0]    w_rem;
    logic [NW:0][NW-1:0]    w_quot;
    logic [NW:0][SBW-1:0]   w_sb;

    assign w_valid[0] = i_valid;
    assign w_num[0]   = i_num;
    assign w_den[0]   = i_den;
    assign w_rem[0]   = '0;
    assign w_quot[0]  = '0;
    assign w_sb[0]    = i_sb;

    for (genvar k = 0; k < NW; k++) begin : g_cell
        tpwm_div_cell #(
            .NW  (NW),
            .DW  (DW),
            .SBW (SBW),
            .BIT (NW - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (w_valid[k]),
            .i_num   (w_num[k]),
            .i_den   (w_den[k]),
            .i_rem   (w_rem[k]),
            .i_quot  (w_quot[k]),
            .i_sb    (w_sb[k]),
            .o_valid (w_valid[k+1]),
            .o_num   (w_num[k+1]),
            .o_den   (w_den[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_quot  (w_quot[k+1]),
            .o_sb    (w_sb[k+1])
        );
    end

    assign o_valid = w_valid[NW];
    assign o_quot  = w_quot[NW];
    assign o_sb    = w_sb[NW];
endmodule

### hw/rtl/tone_pwm_timer_setting_calculator.sv
// ----------------------------------------------------------------------------
// tone_pwm_timer_setting_calculator
// Turns a tone request into timer prescaler, period and compare settings.
// ----------------------------------------------------------------------------
// Takes one item per clock while the output side keeps up and returns one
// result per item, in order. Each item passes an entry stage, a 30-cell
// restoring divider row for the prescaler, a stage between the rows, a
// 30-cell row for the period (each cell resolves one quotient bit), a period
// clamp stage and the compare multiply stage that feeds the output register.
// The whole pipeline advances together and holds while a finished result
// waits at the output; input ready is low only then. The duty divider row
// runs beside the prescaler row. Registers are written over APB (index i at
// byte address 4*i) and must only change while idle.
// ----------------------------------------------------------------------------
module tone_pwm_timer_setting_calculator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tpwm_in_if.sink                       i_in,
    tpwm_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tpwm_pkg::AddrW-1:0]    paddr,
    input  logic [tpwm_pkg::DataW-1:0]    pwdata,
    output logic [tpwm_pkg::DataW-1:0]    prdata,
    output logic                          pready
);
    import tpwm_pkg::*;

    localparam int DutyDW = VolW;
    localparam int DutyNumW = PerW + VolW + 1;
    localparam int Sb1W = 1 + ToneW;
    localparam int Sb2W = 1 + PerW + PerW;

    // ---------------- configuration registers ----------------
    logic [ClkW-1:0] r_clk;
    logic [PerW-1:0] r_maxp;
    logic [PerW-1:0] r_dmin;
    logic [PerW-1:0] r_dmax;
    logic [VolW-1:0] r_vmin;
    logic [VolW-1:0] r_vmax;
    t_reg_idx        w_idx;
    logic            w_wr;

    assign w_idx  = paddr[AddrW-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk  <= RstClk;
            r_maxp <= RstMaxP;
            r_dmin <= RstDMin;
            r_dmax <= RstDMax;
            r_vmin <= RstVMin;
            r_vmax <= RstVMax;
        end else if (w_wr) begin
            unique case (w_idx)
                RegClk:  r_clk  <= pwdata[ClkW-1:0];
                RegMaxP: r_maxp <= pwdata[PerW-1:0];
                RegDMin: r_dmin <= pwdata[PerW-1:0];
                RegDMax: r_dmax <= pwdata[PerW-1:0];
                RegVMin: r_vmin <= pwdata[VolW-1:0];
                RegVMax: r_vmax <= pwdata[VolW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            RegClk:  prdata = DataW'(r_clk);
            RegMaxP: prdata = DataW'(r_maxp);
            RegDMin: prdata = DataW'(r_dmin);
            RegDMax: prdata = DataW'(r_dmax);
            RegVMin: prdata = DataW'(r_vmin);
            RegVMax: prdata = DataW'(r_vmax);
            default: prdata = '0;
        endcase
    end

    // ---------------- pipeline advance ----------------
    // Advance everything unless a result is parked at the output.
    logic r_out_valid;
    logic w_en;
    assign w_en       = !r_out_valid || o_out.ready;
    assign i_in.ready = w_en;

    // ---------------- entry stage ----------------
    // First divisor and the duty numerator, both as products of the request.
    logic                w_silent;
    logic                w_empty;
    logic                w_neg;
    logic [VolW-1:0]     w_vclip;
    logic [VolW-1:0]     w_dv;
    logic [VolW-1:0]     w_den;
    logic [PerW-1:0]     w_mag;
    logic [DutyNumW-1:0] w_prod;
    logic [DutyNumW-1:0] w_dnum;
    logic [DivDenW-1:0]  w_d1;

    always_comb begin
        w_silent = (i_in.tone_hz == '0) || (i_in.loudness <= r_vmin);
        w_empty  = (r_vmax <= r_vmin);
        w_vclip  = (i_in.loudness > r_vmax) ? r_vmax : i_in.loudness;
        if (w_vclip < r_vmin) begin
            w_vclip = r_vmin;
        end
        w_dv   = w_vclip - r_vmin;
        w_den  = r_vmax - r_vmin;
        w_neg  = (r_dmax < r_dmin);
        w_mag  = w_neg ? (r_dmin - r_dmax) : (r_dmax - r_dmin);
        w_prod = DutyNumW'(w_mag) * DutyNumW'(w_dv);
        // round the magnitude up for a falling duty: floor toward minus infinity
        w_dnum = w_neg ? (w_prod + DutyNumW'(w_den) - DutyNumW'(1)) : w_prod;
        w_d1   = DivDenW'(i_in.tone_hz) * DivDenW'({1'b0, r_maxp} + 17'd1);
    end

    logic                r_e_valid;
    logic                r_e_silent;
    logic                r_e_empty;
    logic                r_e_neg;
    logic [ToneW-1:0]    r_e_tone;
    logic [DivDenW-1:0]  r_e_d1;
    logic [DutyNumW-1:0] r_e_dnum;
    logic [DutyDW-1:0]   r_e_dden;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (w_en) begin
            r_e_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_silent <= w_silent;
            r_e_empty  <= w_empty;
            r_e_neg    <= w_neg;
            r_e_tone   <= i_in.tone_hz;
            r_e_d1     <= w_d1;
            r_e_dnum   <= w_dnum;
            r_e_dden   <= w_den;
        end
    end

    // ---------------- prescaler and duty divider rows ----------------
    logic              w_c1_valid;
    logic [ClkW-1:0]   w_c1_quot;
    logic [Sb1W-1:0]   w_c1_sb;
    logic              w_cd_valid;
    logic [ClkW-1:0]   w_cd_quot;
    logic [1:0]        w_cd_sb;

    tpwm_div_chain #(
        .NW  (ClkW),
        .DW  (DivDenW),
        .SBW (Sb1W)
    ) u_presc_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_e_valid),
        .i_num   (r_clk),
        .i_den   (r_e_d1),
        .i_sb    ({r_e_silent, r_e_tone}),
        .o_valid (w_c1_valid),
        .o_quot  (w_c1_quot),
        .o_sb    (w_c1_sb)
    );

    // Same length as the prescaler row so both land together.
    tpwm_div_chain #(
        .NW  (ClkW),
        .DW  (DutyDW),
        .SBW (2)
    ) u_duty_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_e_valid),
        .i_num   (ClkW'(r_e_dnum)),
        .i_den   (r_e_dden),
        .i_sb    ({r_e_neg, r_e_empty}),
        .o_valid (w_cd_valid),
        .o_quot  (w_cd_quot),
        .o_sb    (w_cd_sb)
    );

    // ---------------- middle stage ----------------
    // Saturate prescaler, form the second divisor, finish the duty.
    logic               w_m_silent;
    logic [ToneW-1:0]   w_m_tone;
    logic [PerW-1:0]    w_presc;
    logic [DivDenW-1:0] w_d2;
    logic [PerW-1:0]    w_duty;
    logic [PerW-1:0]    w_dq;

    always_comb begin
        w_m_silent = w_c1_sb[Sb1W-1];
        w_m_tone   = w_c1_sb[ToneW-1:0];
        w_presc    = (w_c1_quot[ClkW-1:PerW] != '0) ? '1 : w_c1_quot[PerW-1:0];
        w_d2       = DivDenW'(w_m_tone) * DivDenW'({1'b0, w_presc} + 17'd1);
        w_dq       = w_cd_quot[PerW-1:0];
        if (w_cd_sb[0]) begin
            w_duty = r_dmax;
        end else if (w_cd_sb[1]) begin
            w_duty = r_dmin - w_dq;
        end else begin
            w_duty = r_dmin + w_dq;
        end
    end

    logic               r_m_valid;
    logic               r_m_silent;
    logic [PerW-1:0]    r_m_presc;
    logic [PerW-1:0]    r_m_duty;
    logic [DivDenW-1:0] r_m_d2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_en) begin
            r_m_valid <= w_c1_valid && w_cd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_silent <= w_m_silent;
            r_m_presc  <= w_presc;
            r_m_duty   <= w_duty;
            r_m_d2     <= w_d2;
        end
    end

    // ---------------- period divider row ----------------
    logic            w_c2_valid;
    logic [ClkW-1:0] w_c2_quot;
    logic [Sb2W-1:0] w_c2_sb;

    tpwm_div_chain #(
        .NW  (ClkW),
        .DW  (DivDenW),
        .SBW (Sb2W)
    ) u_period_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_m_valid),
        .i_num   (r_clk),
        .i_den   (r_m_d2),
        .i_sb    ({r_m_silent, r_m_presc, r_m_duty}),
        .o_valid (w_c2_valid),
        .o_quot  (w_c2_quot),
        .o_sb    (w_c2_sb)
    );

    // ---------------- period clamp stage ----------------
    logic [ClkW-1:0] w_q2m1;
    logic [PerW-1:0] w_per;

    always_comb begin
        w_q2m1 = (w_c2_quot == '0) ? '0 : (w_c2_quot - ClkW'(1));
        w_per  = (w_q2m1 > ClkW'(r_maxp)) ? r_maxp : w_q2m1[PerW-1:0];
    end

    logic            r_p_valid;
    logic            r_p_silent;
    logic [PerW-1:0] r_p_presc;
    logic [PerW-1:0] r_p_duty;
    logic [PerW-1:0] r_p_per;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_en) begin
            r_p_valid <= w_c2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_silent <= w_c2_sb[Sb2W-1];
            r_p_presc  <= w_c2_sb[2*PerW-1:PerW];
            r_p_duty   <= w_c2_sb[PerW-1:0];
            r_p_per    <= w_per;
        end
    end

    // ---------------- compare stage and output register ----------------
    logic [2*PerW-1:0] w_cprod;
    logic [PerW-1:0]   w_cmp;

    always_comb begin
        w_cprod = (2*PerW)'(r_p_duty) * (2*PerW)'(r_p_per);
        w_cmp   = w_cprod[2*PerW-1:PerW];
        if (w_cmp > r_p_per) begin
            w_cmp = r_p_per;
        end
    end

    logic            r_out_silent;
    logic [PerW-1:0] r_out_presc;
    logic [PerW-1:0] r_out_per;
    logic [PerW-1:0] r_out_cmp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_p_valid;
        end
    end

    // Zero the settings of a silent item.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_silent <= r_p_silent;
            r_out_presc  <= r_p_silent ? '0 : r_p_presc;
            r_out_per    <= r_p_silent ? '0 : r_p_per;
            r_out_cmp    <= r_p_silent ? '0 : w_cmp;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.silent    = r_out_silent;
    assign o_out.prescaler = r_out_presc;
    assign o_out.period    = r_out_per;
    assign o_out.compare   = r_out_cmp;
endmodule
